FILE: design/cssf_pkg.sv
// ----------------------------------------------------------------------------
// cssf_pkg
// Types, character codes and helpers shared by the comment strip filter.
// ----------------------------------------------------------------------------
package cssf_pkg;

	localparam int unsigned LINE_OUT_W = 24;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BSL_END = 2'd1;
	localparam logic [1:0] ST_UNTERM  = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_char;
	} item_t;

	typedef struct packed {
		logic [7:0]            out_char;
		logic                  has_char;
		logic [LINE_OUT_W-1:0] line_number;
		logic [1:0]            status;
		logic                  last;
	} res_t;

	typedef enum logic [5:0] {
		M_NORMAL = 6'b000001,
		M_SLASH  = 6'b000010,
		M_LINE   = 6'b000100,
		M_BLOCK  = 6'b001000,
		M_STAR   = 6'b010000,
		M_QUOTE  = 6'b100000
	} mode_t;

	// results of one step, handed from the scanner to the output queue
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} step_t;

	// decision for a byte seen in plain text
	typedef struct packed {
		logic  emit;
		mode_t mode;
		logic  set_splice;
		logic  set_quote;
		logic  quote_single;
	} nb_t;

	function automatic nb_t normal_byte_f(logic [7:0] c);
		nb_t d;
		d.emit         = 1'b0;
		d.mode         = M_NORMAL;
		d.set_splice   = 1'b0;
		d.set_quote    = 1'b0;
		d.quote_single = (c == CH_SQ);
		if (c == CH_BSL) begin
			d.set_splice = 1'b1;
		end else if (c == CH_SLASH) begin
			d.mode = M_SLASH;
		end else if (c == CH_DQ || c == CH_SQ) begin
			d.emit      = 1'b1;
			d.mode      = M_QUOTE;
			d.set_quote = 1'b1;
		end else begin
			d.emit = 1'b1;
		end
		return d;
	endfunction

	function automatic res_t res_f(logic [7:0] ch, logic has,
			logic [LINE_OUT_W-1:0] ln, logic [1:0] st);
		res_t r;
		r.out_char    = has ? ch : 8'h00;
		r.has_char    = has;
		r.line_number = ln;
		r.status      = st;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

FILE: design/cssf_scan.sv
// ----------------------------------------------------------------------------
// cssf_scan
// Scanner state and the per-byte decode: comment, literal and splice
// tracking, line counting, and up to two results per beat.
// ----------------------------------------------------------------------------
module cssf_scan #(
	parameter int unsigned LINE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cssf_pkg::item_t       item,
	input  logic                  take,
	output cssf_pkg::step_t       step
);

	localparam int unsigned EXT_W = (LINE_BITS > cssf_pkg::LINE_OUT_W) ?
		LINE_BITS : cssf_pkg::LINE_OUT_W;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

	cssf_pkg::mode_t        mode_q, mode_n;
	logic                   qs_q, qs_n;
	logic                   sp_q, sp_n;
	logic [LINE_BITS-1:0]   line_q, line_n, line_inc, line_rep;
	logic [EXT_W-1:0]       line_ext;
	logic [cssf_pkg::LINE_OUT_W-1:0] ln;
	logic [7:0]             c;
	logic                   is_end;

	assign c        = item.in_char;
	assign is_end   = (item.opcode == cssf_pkg::OP_END);
	assign line_inc = (c == cssf_pkg::CH_NL && line_q != LINE_MAX) ?
		line_q + 1'b1 : line_q;
	assign line_rep = is_end ? line_q : line_inc;
	assign line_ext = EXT_W'(line_rep);
	assign ln       = line_ext[cssf_pkg::LINE_OUT_W-1:0];

	always_comb begin
		cssf_pkg::nb_t nb;
		logic [1:0]    st;
		logic          has;
		logic [7:0]    ch;
		nb     = cssf_pkg::normal_byte_f(c);
		st     = cssf_pkg::ST_OK;
		has    = 1'b0;
		ch     = 8'h00;
		mode_n = mode_q;
		qs_n   = qs_q;
		sp_n   = 1'b0;
		line_n = line_inc;
		step.count = 2'd0;
		step.r0    = cssf_pkg::res_f(8'h00, 1'b0, ln, cssf_pkg::ST_OK);
		step.r1    = cssf_pkg::res_f(8'h00, 1'b0, ln, cssf_pkg::ST_OK);

		if (is_end) begin
			if (sp_q) begin
				st = cssf_pkg::ST_BSL_END;
			end else if (mode_q == cssf_pkg::M_SLASH) begin
				has = 1'b1;
				ch  = cssf_pkg::CH_SLASH;
			end else if (mode_q == cssf_pkg::M_BLOCK || mode_q == cssf_pkg::M_STAR) begin
				st = cssf_pkg::ST_UNTERM;
			end
			step.count = 2'd1;
			step.r0    = cssf_pkg::res_f(ch, has, ln, st);
			mode_n     = cssf_pkg::M_NORMAL;
			qs_n       = 1'b0;
			line_n     = '0;
		end else if (sp_q && mode_q != cssf_pkg::M_SLASH && mode_q != cssf_pkg::M_LINE &&
				mode_q != cssf_pkg::M_BLOCK && mode_q != cssf_pkg::M_STAR) begin
			// escaped byte: passed on with its backslash, newline is spliced out
			mode_n = (mode_q == cssf_pkg::M_QUOTE) ? cssf_pkg::M_QUOTE : cssf_pkg::M_NORMAL;
			if (c != cssf_pkg::CH_NL) begin
				step.count = 2'd2;
				step.r0    = cssf_pkg::res_f(cssf_pkg::CH_BSL, 1'b1, ln, cssf_pkg::ST_OK);
				step.r1    = cssf_pkg::res_f(c, 1'b1, ln, cssf_pkg::ST_OK);
			end
		end else begin
			unique case (mode_q)
				cssf_pkg::M_SLASH: begin
					if (c == cssf_pkg::CH_SLASH) begin
						mode_n = cssf_pkg::M_LINE;
					end else if (c == cssf_pkg::CH_STAR) begin
						mode_n = cssf_pkg::M_BLOCK;
					end else begin
						// held slash goes out first, then the byte as plain text
						step.r0 = cssf_pkg::res_f(cssf_pkg::CH_SLASH, 1'b1, ln,
							cssf_pkg::ST_OK);
						step.r1 = cssf_pkg::res_f(c, 1'b1, ln, cssf_pkg::ST_OK);
						step.count = nb.emit ? 2'd2 : 2'd1;
						mode_n = nb.mode;
						sp_n   = nb.set_splice;
						if (nb.set_quote) begin
							qs_n = nb.quote_single;
						end
					end
				end
				cssf_pkg::M_LINE: begin
					if (c == cssf_pkg::CH_NL) begin
						step.count = 2'd1;
						step.r0    = cssf_pkg::res_f(c, 1'b1, ln, cssf_pkg::ST_OK);
						mode_n     = cssf_pkg::M_NORMAL;
					end
				end
				cssf_pkg::M_BLOCK: begin
					if (c == cssf_pkg::CH_STAR) begin
						mode_n = cssf_pkg::M_STAR;
					end
				end
				cssf_pkg::M_STAR: begin
					if (c == cssf_pkg::CH_SLASH) begin
						mode_n = cssf_pkg::M_NORMAL;
					end else if (c != cssf_pkg::CH_STAR) begin
						mode_n = cssf_pkg::M_BLOCK;
					end
				end
				cssf_pkg::M_QUOTE: begin
					if (c == cssf_pkg::CH_BSL) begin
						sp_n = 1'b1;
					end else begin
						step.count = 2'd1;
						step.r0    = cssf_pkg::res_f(c, 1'b1, ln, cssf_pkg::ST_OK);
						if (c == (qs_q ? cssf_pkg::CH_SQ : cssf_pkg::CH_DQ)) begin
							mode_n = cssf_pkg::M_NORMAL;
						end
					end
				end
				default: begin
					// plain text, and any corrupt mode code
					step.r0    = cssf_pkg::res_f(c, 1'b1, ln, cssf_pkg::ST_OK);
					step.count = nb.emit ? 2'd1 : 2'd0;
					mode_n     = nb.mode;
					sp_n       = nb.set_splice;
					if (nb.set_quote) begin
						qs_n = nb.quote_single;
					end
				end
			endcase
		end
		step.r0.last = (step.count == 2'd1);
		step.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cssf_pkg::M_NORMAL;
			qs_q   <= 1'b0;
			sp_q   <= 1'b0;
			line_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			qs_q   <= qs_n;
			sp_q   <= sp_n;
			line_q <= line_n;
		end
	end

endmodule

FILE: design/cssf_outq.sv
// ----------------------------------------------------------------------------
// cssf_outq
// Two-entry result queue; takes zero, one or two results per cycle and
// presents them one beat at a time.
// ----------------------------------------------------------------------------
module cssf_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  cssf_pkg::step_t  step,
	input  logic             push,
	input  logic             res_ready,
	output logic             res_valid,
	output cssf_pkg::res_t   head,
	output logic [1:0]       free
);

	cssf_pkg::res_t e0_q, e1_q, a0;
	logic [1:0]     cnt_q, cnt_p, add;
	logic           pop;

	assign res_valid = (cnt_q != 2'd0);
	assign head      = e0_q;
	assign pop       = res_valid && res_ready;
	assign free      = 2'd2 - cnt_q + {1'b0, pop};
	assign cnt_p     = cnt_q - {1'b0, pop};
	assign a0        = pop ? e1_q : e0_q;
	assign add       = push ? step.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_p + add;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= (cnt_p == 2'd0) ? step.r0 : a0;
		e1_q <= (cnt_p == 2'd0) ? step.r1 : ((cnt_p == 2'd1) ? step.r0 : e1_q);
	end

endmodule

FILE: design/comment_strip_splice_filter.sv
// ----------------------------------------------------------------------------
// comment_strip_splice_filter
// Strips // and block comments from source text outside literals, splices
// backslash-newline and counts raw newlines.
// ----------------------------------------------------------------------------
//  channel | signals                           | beat
//  --------+-----------------------------------+------------------------------
//  byte    | byte_valid, byte_ready, byte_beat | opcode, in_char
//  res     | res_valid, res_ready, res_beat    | out_char, has_char,
//          |                                   | line_number, status, last
//
// One byte beat per cycle while byte_ready is high. A beat is registered in
// the input register and decoded there; its results are registered in the
// two-entry queue before they appear. A beat with two results fills the
// queue; if the next beat also has two results it waits and byte_ready drops
// while it waits. A stalled res side fills the queue and then the input
// register. Reset clears scanner state and queue.
// ----------------------------------------------------------------------------
module comment_strip_splice_filter #(
	parameter int unsigned LINE_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  cssf_pkg::item_t  byte_beat,
	output logic             res_valid,
	input  logic             res_ready,
	output cssf_pkg::res_t   res_beat
);

	cssf_pkg::item_t item_s1;
	logic            vld_s1;
	cssf_pkg::step_t step;
	logic [1:0]      free;
	logic            fire;

	// decode the held beat only when its results all fit in the queue
	assign fire       = vld_s1 && (step.count <= free);
	assign byte_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ready) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_beat;
		end
	end

	cssf_scan #(
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (fire),
		.step   (step)
	);

	cssf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.push      (fire),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.head      (res_beat),
		.free      (free)
	);

endmodule

FILE: bench/comment_strip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_strip_checker
// Watches both channels of the comment strip filter. Each accepted byte beat
// runs through a scanner model that queues the result beats it should cause.
// Each accepted result beat is compared field by field with the oldest queued
// one. Reports the mismatch count and the number of results still owed.
// ----------------------------------------------------------------------------
module comment_strip_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic             byte_ready,
	input  cssf_pkg::item_t  byte_beat,
	input  logic             res_valid,
	input  logic             res_ready,
	input  cssf_pkg::res_t   res_beat,
	output int               mismatches,
	output int               outstanding
);
	import cssf_pkg::*;

	mode_t                 mode;
	logic                  quote_sq;
	logic                  splice;
	logic [LINE_OUT_W-1:0] line_cnt;
	res_t                  owed_results[$];
	int                    fails;

	task automatic clear_scan();
		mode     = M_NORMAL;
		quote_sq = 1'b0;
		splice   = 1'b0;
		line_cnt = '0;
	endtask

	task automatic owe(logic [7:0] ch, logic has, logic [1:0] st);
		res_t r;
		r.out_char    = has ? ch : 8'h00;
		r.has_char    = has;
		r.line_number = line_cnt;
		r.status      = st;
		r.last        = 1'b0;
		owed_results.push_back(r);
	endtask

	// byte seen as plain text; a backslash leaves the mode alone
	task automatic plain_text(logic [7:0] c);
		if (c == CH_BSL) begin
			splice = 1'b1;
		end else if (c == CH_SLASH) begin
			mode = M_SLASH;
		end else if (c == CH_DQ || c == CH_SQ) begin
			owe(c, 1'b1, ST_OK);
			mode     = M_QUOTE;
			quote_sq = (c == CH_SQ);
		end else begin
			mode = M_NORMAL;
			owe(c, 1'b1, ST_OK);
		end
	endtask

	task automatic scan_beat(item_t it);
		int          first;
		logic [7:0]  c;
		logic [1:0]  st;
		logic        has;
		logic [7:0]  ch;
		first = owed_results.size();
		c     = it.in_char;
		if (it.opcode == OP_END) begin
			st  = ST_OK;
			has = 1'b0;
			ch  = 8'h00;
			if (splice) begin
				st = ST_BSL_END;
			end else if (mode == M_SLASH) begin
				has = 1'b1;
				ch  = CH_SLASH;
			end else if (mode == M_BLOCK || mode == M_STAR) begin
				st = ST_UNTERM;
			end
			owe(ch, has, st);
			clear_scan();
		end else begin
			if (c == CH_NL && line_cnt != {LINE_OUT_W{1'b1}})
				line_cnt = line_cnt + 1'b1;
			if (splice && (mode == M_NORMAL || mode == M_QUOTE)) begin
				splice = 1'b0;
				if (c != CH_NL) begin
					owe(CH_BSL, 1'b1, ST_OK);
					owe(c, 1'b1, ST_OK);
				end
			end else begin
				splice = 1'b0;
				case (mode)
					M_SLASH: begin
						if (c == CH_SLASH) begin
							mode = M_LINE;
						end else if (c == CH_STAR) begin
							mode = M_BLOCK;
						end else begin
							owe(CH_SLASH, 1'b1, ST_OK);
							mode = M_NORMAL;
							plain_text(c);
						end
					end
					M_LINE: begin
						if (c == CH_NL) begin
							owe(c, 1'b1, ST_OK);
							mode = M_NORMAL;
						end
					end
					M_BLOCK: begin
						if (c == CH_STAR)
							mode = M_STAR;
					end
					M_STAR: begin
						if (c == CH_SLASH)
							mode = M_NORMAL;
						else if (c != CH_STAR)
							mode = M_BLOCK;
					end
					M_QUOTE: begin
						if (c == CH_BSL) begin
							splice = 1'b1;
						end else begin
							owe(c, 1'b1, ST_OK);
							if (c == (quote_sq ? CH_SQ : CH_DQ))
								mode = M_NORMAL;
						end
					end
					default: begin
						plain_text(c);
					end
				endcase
			end
		end
		if (owed_results.size() > first)
			owed_results[owed_results.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (owed_results.size() == 0) begin
			$error("result beat with nothing owed: out_char %0h has_char %0b last %0b",
				got.out_char, got.has_char, got.last);
			fails++;
		end else begin
			want = owed_results.pop_front();
			check_field("out_char", 32'(want.out_char), 32'(got.out_char));
			check_field("has_char", 32'(want.has_char), 32'(got.has_char));
			check_field("line_number", 32'(want.line_number), 32'(got.line_number));
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("last", 32'(want.last), 32'(got.last));
		end
	endtask

	initial fails = 0;

	// results of a byte are registered before they show up, so pop before push
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			owed_results.delete();
		end else begin
			if (res_valid && res_ready)
				check_result(res_beat);
			if (byte_valid && byte_ready)
				scan_beat(byte_beat);
		end
		mismatches  <= fails;
		outstanding <= owed_results.size();
	end

endmodule

FILE: bench/comment_strip_splice_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_strip_splice_filter_tb
// Drives source text into the comment strip filter: a short directed run over
// comments, literals, splices and every kind of end, then random token
// streams with random gaps on both sides, one long result stall and one full
// drain. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module comment_strip_splice_filter_tb;
	import cssf_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TOTAL_BEATS  = 530;
	localparam int SETTLE       = 20;

	logic  clk;
	logic  arst_n;
	logic  byte_valid;
	logic  byte_ready;
	item_t byte_beat;
	logic  res_valid;
	logic  res_ready;
	res_t  res_beat;

	int    mismatches;
	int    outstanding;
	int    sent;
	int    hold_reqs;
	int    holds_done;
	int    quiet_cycles;
	logic  calm;
	logic  drained;

	comment_strip_splice_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_beat  (byte_beat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_beat   (res_beat)
	);

	comment_strip_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_beat   (byte_beat),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_beat    (res_beat),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: no beat on either channel for too long
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (res_valid && res_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		res_ready  = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				res_ready <= calm || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	task automatic send_beat(item_t it);
		while (!calm && $urandom_range(0, 99) < 14) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= it;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_byte(logic [7:0] c);
		item_t it;
		it.opcode  = OP_BYTE;
		it.in_char = c;
		send_beat(it);
	endtask

	task automatic send_end();
		item_t it;
		it.opcode  = OP_END;
		it.in_char = 8'($urandom_range(0, 255));
		send_beat(it);
	endtask

	task automatic send_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// half the time a delimiter, else any byte
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 5))
				0: c = CH_SLASH;
				1: c = CH_STAR;
				2: c = CH_BSL;
				3: c = CH_DQ;
				4: c = CH_SQ;
				default: c = CH_NL;
			endcase
		end
		return c;
	endfunction

	task automatic send_token();
		int kind;
		int n;
		int i;
		kind = $urandom_range(0, 99);
		n    = $urandom_range(1, 6);
		if (kind < 25) begin
			for (i = 0; i < n; i++)
				send_byte(pick_char());
		end else if (kind < 40) begin
			send_byte(CH_SLASH);
			send_byte(CH_SLASH);
			for (i = 0; i < n; i++)
				send_byte(pick_char());
			send_byte(CH_NL);
		end else if (kind < 55) begin
			send_byte(CH_SLASH);
			send_byte(CH_STAR);
			for (i = 0; i < n; i++)
				send_byte(pick_char());
			repeat ($urandom_range(1, 3)) send_byte(CH_STAR);
			send_byte(CH_SLASH);
		end else if (kind < 70) begin
			send_byte(CH_DQ);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0)
					send_byte(CH_BSL);
				send_byte(pick_char());
			end
			send_byte(CH_DQ);
		end else if (kind < 78) begin
			send_byte(CH_SQ);
			if ($urandom_range(0, 1) == 0)
				send_byte(CH_BSL);
			send_byte(pick_char());
			send_byte(CH_SQ);
		end else if (kind < 84) begin
			send_byte(CH_BSL);
			send_byte(CH_NL);
		end else if (kind < 90) begin
			send_byte(CH_BSL);
			send_byte(pick_char());
		end else if (kind < 97) begin
			for (i = 0; i < n; i++)
				send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_end();
		end
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		arst_n     = 1'b1;
		byte_valid = 1'b0;
		byte_beat  = '0;
		calm       = 1'b0;
		drained    = 1'b0;
		hold_reqs  = 0;
		sent       = 0;
		// assert reset after time zero so every flop sees the edge
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("/x//c\n");
		send_text("/*\\**/");
		send_text("\"/\n\\\"\"");
		send_text("'\\''\\\n");
		send_end();
		send_text("/");
		send_end();
		send_text("\\");
		send_end();
		send_text("/*");
		send_end();

		while (sent < TOTAL_BEATS) begin
			calm <= (sent >= 200 && sent < 300);
			if (hold_reqs == 0 && sent >= 120)
				hold_reqs <= 1;
			if (!drained && sent >= 340) begin
				drained = 1'b1;
				wait_drained();
			end
			send_token();
		end
		send_end();

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
